>>> src/tarc_pkg.sv
package tarc_pkg;

   localparam int ANGLE_FRAC_BITS     = 8;
   localparam int DEF_CORDIC_STEPS    = 16;
   localparam int DEF_COUNT_WIDTH     = 16;
   localparam int ATAN_TABLE_LEN      = 24;
   localparam int ATAN_FRAC           = 16;
   localparam int SQRT_STEPS          = 24;
   localparam int STEP_IDX_WIDTH      = 5;

   localparam logic [15:0] ALPHA_RESET = 16'd6554;
   localparam logic [15:0] RISE_RESET  = 16'd5120;
   localparam logic [15:0] PEAK_RESET  = 16'd20480;
   localparam logic [15:0] FALL_RESET  = 16'd3840;

   localparam logic [15:0] ANGLE_LIMIT = 16'(90 << ANGLE_FRAC_BITS);
   localparam logic [15:0] ZONE1_LEVEL = 16'(30 << ANGLE_FRAC_BITS);
   localparam logic [15:0] ZONE2_LEVEL = 16'(60 << ANGLE_FRAC_BITS);
   localparam logic [15:0] ZONE3_LEVEL = 16'(90 << ANGLE_FRAC_BITS);

   localparam logic [1:0] ZONE_NONE = 2'd0;
   localparam logic [1:0] ZONE_30   = 2'd1;
   localparam logic [1:0] ZONE_60   = 2'd2;
   localparam logic [1:0] ZONE_90   = 2'd3;

   localparam logic       CMD_SAMPLE    = 1'b0;
   localparam logic       CMD_CALIBRATE = 1'b1;

   localparam logic [1:0] REG_ALPHA = 2'd0;
   localparam logic [1:0] REG_RISE  = 2'd1;
   localparam logic [1:0] REG_PEAK  = 2'd2;
   localparam logic [1:0] REG_FALL  = 2'd3;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] filtered_angle;
      logic [15:0]        relative_angle;
      logic [15:0]        rep_count;
      logic               rep_done;
      logic [1:0]         goal_zone;
      logic               is_calibrated;
      logic               sample_skipped;
   } rsp_type;

   typedef struct packed {
      logic [15:0] filter_alpha;
      logic [15:0] rise_threshold;
      logic [15:0] peak_threshold;
      logic [15:0] fall_threshold;
   } cfg_type;

   typedef struct packed {
      logic                      load;
      logic                      sq_x;
      logic                      sq_z;
      logic                      sqrt_step;
      logic                      cordic_init;
      logic                      cordic_step;
      logic                      angle;
      logic                      mul;
      logic                      filt;
      logic                      commit;
      logic [STEP_IDX_WIDTH-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic bypass;
   } dp_status_type;

   // atan(2^-i) in degrees, Q.16, rounded to nearest.
   function automatic logic signed [24:0] atan_entry(input logic [STEP_IDX_WIDTH-1:0] i);
      logic signed [24:0] v;
      case (i)
         5'd0:    v = 25'sd2949120;
         5'd1:    v = 25'sd1740967;
         5'd2:    v = 25'sd919879;
         5'd3:    v = 25'sd466945;
         5'd4:    v = 25'sd234379;
         5'd5:    v = 25'sd117304;
         5'd6:    v = 25'sd58666;
         5'd7:    v = 25'sd29335;
         5'd8:    v = 25'sd14668;
         5'd9:    v = 25'sd7334;
         5'd10:   v = 25'sd3667;
         5'd11:   v = 25'sd1833;
         5'd12:   v = 25'sd917;
         5'd13:   v = 25'sd458;
         5'd14:   v = 25'sd229;
         5'd15:   v = 25'sd115;
         5'd16:   v = 25'sd57;
         5'd17:   v = 25'sd29;
         5'd18:   v = 25'sd14;
         5'd19:   v = 25'sd7;
         5'd20:   v = 25'sd4;
         5'd21:   v = 25'sd2;
         5'd22:   v = 25'sd1;
         default: v = 25'sd0;
      endcase
      return v;
   endfunction

endpackage

>>> src/tilt_angle_repetition_counter.sv
// Tilt angle repetition counter.
// Input beats on req_* carry a command and one raw 3-axis accelerometer
// sample; each accepted beat yields exactly one result beat on rsp_*.
// A sample beat computes the roll angle with a bit-serial square root and a
// CORDIC vectoring loop, then a low-pass filter and the rise/peak/fall
// repetition machine. A calibrate beat or an all-zero sample skips the
// square root, CORDIC and filter steps. One item is in flight at a time,
// so a new beat is taken only once the previous result has been loaded.
// The result sits in an output register; while the receiver stalls, the
// next item is still accepted and computed, and its state update waits
// until the held result has been taken.
// Reset clears the filter, zero offset, flags and count, and restores the
// register defaults. Registers are written through the csr_* port; the user
// must write them only while the block is idle, as the block does not check.
module tilt_angle_repetition_counter
   import tarc_pkg::*;
#(
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
   parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   tarc_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   tarc_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .status, .cmd
   );

   tarc_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock, .reset, .req_data, .cfg, .cmd, .status, .rsp_data
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in flight");

   a_done_needs_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rep_done |-> rsp_data.is_calibrated)
      else $error("repetition reported before calibration");

   a_skip_no_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sample_skipped |-> !rsp_data.rep_done)
      else $error("skipped sample completed a repetition");

   a_zone_uncal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_calibrated |-> rsp_data.goal_zone == ZONE_NONE)
      else $error("goal zone reported before calibration");

endmodule

>>> src/tarc_csr.sv
module tarc_csr
   import tarc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_alpha   <= ALPHA_RESET;
         cfg_ff.rise_threshold <= RISE_RESET;
         cfg_ff.peak_threshold <= PEAK_RESET;
         cfg_ff.fall_threshold <= FALL_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_ALPHA: cfg_ff.filter_alpha   <= csr_pwdata[15:0];
            REG_RISE:  cfg_ff.rise_threshold <= csr_pwdata[15:0];
            REG_PEAK:  cfg_ff.peak_threshold <= csr_pwdata[15:0];
            REG_FALL:  cfg_ff.fall_threshold <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ALPHA: csr_prdata = {16'h0, cfg_ff.filter_alpha};
         REG_RISE:  csr_prdata = {16'h0, cfg_ff.rise_threshold};
         REG_PEAK:  csr_prdata = {16'h0, cfg_ff.peak_threshold};
         REG_FALL:  csr_prdata = {16'h0, cfg_ff.fall_threshold};
         default:   csr_prdata = 32'h0;
      endcase
   end

endmodule

>>> src/tarc_ctrl.sv
module tarc_ctrl
   import tarc_pkg::*;
#(
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_SQX, S_SQZ, S_SQRT, S_CINIT, S_CORDIC, S_ANGLE, S_MUL, S_FILT, S_WRITE
   } state_type;

   state_type                 state_ff, state_in;
   logic [STEP_IDX_WIDTH-1:0] cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.idx  = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = S_SQX;
         end
         S_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = status.bypass ? S_WRITE : S_SQZ;
         end
         S_SQZ: begin
            cmd.sq_z = 1'b1;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == STEP_IDX_WIDTH'(SQRT_STEPS - 1)) state_in = S_CINIT;
         end
         S_CINIT: begin
            cmd.cordic_init = 1'b1;
            cnt_in          = '0;
            state_in        = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == STEP_IDX_WIDTH'(CORDIC_STEPS - 1)) state_in = S_ANGLE;
         end
         S_ANGLE: begin
            cmd.angle = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FILT;
         end
         S_FILT: begin
            cmd.filt = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // The state update and the result load happen together, once the
            // output register can take a new beat.
            cmd.commit = out_free;
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/tarc_dp.sv
module tarc_dp
   import tarc_pkg::*;
#(
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  cfg_type       cfg,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   req_type                  item_ff;
   logic [31:0]              acc_ff;
   logic [47:0]              rad_ff;
   logic [24:0]              rem_ff;
   logic [23:0]              root_ff;
   logic signed [27:0]       cx_ff, cy_ff;
   logic signed [24:0]       cz_ff;
   logic signed [15:0]       ang_ff;
   logic signed [41:0]       prod_ff;
   logic signed [23:0]       snew_ff;
   rsp_type                  rsp_ff;

   logic signed [23:0]       filt_ff, filt_in;
   logic signed [23:0]       zoff_ff, zoff_in;
   logic [15:0]              rel_ff, rel_in;
   logic                     cal_ff, cal_in;
   logic                     rise_ff, rise_in;
   logic                     top_ff, top_in;
   logic [COUNT_WIDTH-1:0]   rep_ff, rep_in;

   logic                     is_zero;
   logic signed [31:0]       sq_prod;
   logic signed [15:0]       sq_op;
   logic [26:0]              rem_sh, trial;
   logic signed [27:0]       xs, ys;
   logic signed [24:0]       tab;
   logic signed [24:0]       zr;
   logic signed [24:0]       diff;
   logic signed [25:0]       delta;
   logic signed [24:0]       rdiff;
   logic [16:0]              rround;
   logic                     done;
   logic [1:0]               zone;
   logic signed [23:0]       fa_full;
   logic [32:0]              cnt_ext;

   localparam int TAB_SHIFT = ATAN_FRAC - ANGLE_FRAC_BITS;

   assign is_zero       = (item_ff.accel_x == 16'sd0) && (item_ff.accel_y == 16'sd0)
                          && (item_ff.accel_z == 16'sd0);
   assign status.bypass = (item_ff.cmd == CMD_CALIBRATE) || is_zero;

   // One shared squarer serves both axes.
   assign sq_op   = cmd.sq_x ? item_ff.accel_x : item_ff.accel_z;
   assign sq_prod = sq_op * sq_op;

   assign rem_sh = {rem_ff, rad_ff[47:46]};
   assign trial  = {1'b0, root_ff, 2'b01};

   assign xs  = cx_ff >>> cmd.idx;
   assign ys  = cy_ff >>> cmd.idx;
   assign tab = atan_entry(cmd.idx);

   assign zr    = (cz_ff + (25'sd1 <<< (TAB_SHIFT - 1))) >>> TAB_SHIFT;
   assign diff  = 25'(ang_ff <<< 8) - 25'(filt_ff);
   assign delta = 26'((prod_ff + 42'sd32768) >>> 16);

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_data;
      if (cmd.sq_x) acc_ff <= 32'(sq_prod);
      if (cmd.sq_z) begin
         rad_ff  <= {acc_ff + 32'(sq_prod), 16'h0};
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[45:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= 25'(rem_sh - trial);
            root_ff <= {root_ff[22:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[24:0];
            root_ff <= {root_ff[22:0], 1'b0};
         end
      end
      if (cmd.cordic_init) begin
         cx_ff <= {4'h0, root_ff};
         cy_ff <= {{4{item_ff.accel_y[15]}}, item_ff.accel_y, 8'h00};
         cz_ff <= '0;
      end
      if (cmd.cordic_step) begin
         if (cy_ff > 28'sd0) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + tab;
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - tab;
         end
      end
      if (cmd.angle) begin
         if (zr > 25'($signed({1'b0, ANGLE_LIMIT}))) ang_ff <= $signed(ANGLE_LIMIT);
         else if (zr < -25'($signed({1'b0, ANGLE_LIMIT}))) ang_ff <= -$signed(ANGLE_LIMIT);
         else ang_ff <= zr[15:0];
      end
      if (cmd.mul) prod_ff <= $signed({1'b0, cfg.filter_alpha}) * diff;
      if (cmd.filt) snew_ff <= 24'(26'(filt_ff) + delta);
      if (cmd.commit) rsp_ff <= '{filtered_angle: fa_full[15:0], relative_angle: rel_in,
                                  rep_count: (cnt_ext > 33'd65535) ? 16'hFFFF : cnt_ext[15:0],
                                  rep_done: done, goal_zone: zone, is_calibrated: cal_in,
                                  sample_skipped: (item_ff.cmd == CMD_SAMPLE) && is_zero};
   end

   always_comb begin
      filt_in = filt_ff;
      zoff_in = zoff_ff;
      rel_in  = rel_ff;
      cal_in  = cal_ff;
      rise_in = rise_ff;
      top_in  = top_ff;
      rep_in  = rep_ff;
      done    = 1'b0;
      rdiff   = 25'(snew_ff) - 25'(zoff_ff);
      rround  = rdiff[24] ? 17'd0 : 17'((rdiff + 25'sd128) >>> 8);
      if (item_ff.cmd == CMD_CALIBRATE) begin
         zoff_in = filt_ff;
         cal_in  = 1'b1;
         rep_in  = '0;
      end else if (!is_zero) begin
         filt_in = snew_ff;
         if (cal_ff) begin
            rel_in = rround[16] ? 16'hFFFF : rround[15:0];
            if (rel_in > cfg.rise_threshold && !rise_in) begin
               rise_in = 1'b1;
               top_in  = 1'b0;
            end
            if (rel_in > cfg.peak_threshold && rise_in) top_in = 1'b1;
            if (rel_in < cfg.fall_threshold && top_in) begin
               if (rep_ff != '1) rep_in = rep_ff + 1'b1;
               rise_in = 1'b0;
               top_in  = 1'b0;
               done    = 1'b1;
            end
         end
      end
      zone = ZONE_NONE;
      if (cal_in) begin
         if (rel_in >= ZONE3_LEVEL) zone = ZONE_90;
         else if (rel_in >= ZONE2_LEVEL) zone = ZONE_60;
         else if (rel_in >= ZONE1_LEVEL) zone = ZONE_30;
      end
      fa_full = (filt_in + 24'sd128) >>> 8;
      cnt_ext = 33'(rep_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
         zoff_ff <= '0;
         rel_ff  <= '0;
         cal_ff  <= 1'b0;
         rise_ff <= 1'b0;
         top_ff  <= 1'b0;
         rep_ff  <= '0;
      end else if (cmd.commit) begin
         filt_ff <= filt_in;
         zoff_ff <= zoff_in;
         rel_ff  <= rel_in;
         cal_ff  <= cal_in;
         rise_ff <= rise_in;
         top_ff  <= top_in;
         rep_ff  <= rep_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> verif/testbench.sv
module testbench;
   import tarc_pkg::*;

   localparam int DRAIN_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tilt_angle_repetition_counter DUT (.*);

   always #10 clock = ~clock;

   // Register shadows and the expected-state copy of the counter.
   logic [15:0] alpha_q16, rise_level, peak_level, fall_level;
   longint      filt_q16, offset_q16;
   logic [15:0] rel_q8;
   bit          calibrated, rising, at_top;
   logic [15:0] rep_total;

   rsp_type     pending_results[$];
   int          send_idle_pct, recv_stall_pct;
   int          mismatches, beats_sent, beats_checked, reps_seen, skips_seen, cals_sent;

   const longint atan_q16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

   function automatic longint roll_degrees(longint ax, longint ay, longint az);
      longint unsigned rem, root, probe;
      longint x, y, z, xs, ys;
      rem = longint'(ax * ax + az * az) << 16;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      x = longint'(root);
      y = ay * 256;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z += atan_q16[i];
         end else begin
            x = x - ys; y = y + xs; z -= atan_q16[i];
         end
      end
      z = (z + 128) >>> 8;
      if (z > 23040) z = 23040;
      if (z < -23040) z = -23040;
      return z;
   endfunction

   function automatic rsp_type compute_tilt_result(req_type item);
      rsp_type res;
      longint  r;
      res = '0;
      if (item.cmd == CMD_CALIBRATE) begin
         offset_q16 = filt_q16;
         calibrated = 1'b1;
         rep_total = '0;
      end else if (item.accel_x == 0 && item.accel_y == 0 && item.accel_z == 0) begin
         res.sample_skipped = 1'b1;
      end else begin
         r = roll_degrees(item.accel_x, item.accel_y, item.accel_z) * 256;
         filt_q16 += (longint'(alpha_q16) * (r - filt_q16) + 32768) >>> 16;
         if (calibrated) begin
            r = filt_q16 - offset_q16;
            if (r < 0) r = 0;
            r = (r + 128) >>> 8;
            if (r > 65535) r = 65535;
            rel_q8 = r[15:0];
            if (rel_q8 > rise_level && !rising) begin
               rising = 1'b1;
               at_top = 1'b0;
            end
            if (rel_q8 > peak_level && rising) at_top = 1'b1;
            if (rel_q8 < fall_level && at_top) begin
               if (rep_total != 16'hFFFF) rep_total++;
               rising = 1'b0;
               at_top = 1'b0;
               res.rep_done = 1'b1;
            end
         end
      end
      if (calibrated) begin
         if (rel_q8 >= ZONE3_LEVEL) res.goal_zone = ZONE_90;
         else if (rel_q8 >= ZONE2_LEVEL) res.goal_zone = ZONE_60;
         else if (rel_q8 >= ZONE1_LEVEL) res.goal_zone = ZONE_30;
         else res.goal_zone = ZONE_NONE;
      end
      r = (filt_q16 + 128) >>> 8;
      res.filtered_angle = r[15:0];
      res.relative_angle = rel_q8;
      res.rep_count = rep_total;
      res.is_calibrated = calibrated;
      return res;
   endfunction

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch on beat %0d, %s: expected %0h, got %0h",
                     beats_checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat %h", rsp_data);
         end else begin
            want = pending_results.pop_front();
            check_field("filtered_angle", want.filtered_angle, rsp_data.filtered_angle);
            check_field("relative_angle", want.relative_angle, rsp_data.relative_angle);
            check_field("rep_count", want.rep_count, rsp_data.rep_count);
            check_field("rep_done", want.rep_done, rsp_data.rep_done);
            check_field("goal_zone", want.goal_zone, rsp_data.goal_zone);
            check_field("is_calibrated", want.is_calibrated, rsp_data.is_calibrated);
            check_field("sample_skipped", want.sample_skipped, rsp_data.sample_skipped);
            if (want.rep_done) reps_seen++;
            if (want.sample_skipped) skips_seen++;
         end
         beats_checked++;
      end
   end

   // Called right after a rising edge; returns at the edge that took the beat, or after a random idle gap.
   task automatic send_beat(req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(compute_tilt_result(item));
      beats_sent++;
      if (item.cmd == CMD_CALIBRATE) cals_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_sample(int ax, int ay, int az);
      req_type item;
      item.cmd = CMD_SAMPLE;
      item.accel_x = 16'(ax);
      item.accel_y = 16'(ay);
      item.accel_z = 16'(az);
      send_beat(item);
   endtask

   task automatic send_calibrate();
      req_type item;
      item.cmd = CMD_CALIBRATE;
      item.accel_x = 16'($urandom);
      item.accel_y = 16'($urandom);
      item.accel_z = 16'($urandom);
      send_beat(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ALPHA: alpha_q16 = value;
         REG_RISE:  rise_level = value;
         REG_PEAK:  peak_level = value;
         REG_FALL:  fall_level = value;
         default: ;
      endcase
   endtask

   task automatic write_all(logic [15:0] a, logic [15:0] r, logic [15:0] p, logic [15:0] f);
      wait_idle();
      write_reg(REG_ALPHA, a);
      write_reg(REG_RISE, r);
      write_reg(REG_PEAK, p);
      write_reg(REG_FALL, f);
   endtask

   task automatic test_special_samples();
      send_sample(0, 0, 0);
      send_calibrate();
      send_sample(0, 0, 0);
      send_sample(0, 32767, 0);
      send_sample(0, -32768, 0);
      send_sample(-32768, -32768, -32768);
      send_sample(32767, 32767, 32767);
      send_sample(32767, 0, 0);
      send_sample(0, 0, -32768);
      send_sample(1, 0, 0);
      send_sample(0, 1, 0);
      send_sample(0, 0, 1);
      send_sample(-1, -1, -1);
      send_calibrate();
      send_calibrate();
   endtask

   task automatic test_register_extremes();
      // With all thresholds wide open, each calibrated sample above the zero point counts a repetition.
      write_all(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      send_sample(0, -20000, 1000);
      send_calibrate();
      send_sample(0, 30000, 1000);
      send_sample(0, 30000, 1000);
      send_sample(0, -30000, 1000);
      // A zero weight freezes the filter; thresholds at the top never fire.
      write_all(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
      send_sample(0, 30000, 1000);
      send_sample(5, -30000, 1000);
      write_all(ALPHA_RESET, RISE_RESET, PEAK_RESET, FALL_RESET);
      send_sample(0, 12000, 12000);
   endtask

   // One lift and lowering of the limb, at times after a calibration, with noise on the side axis.
   task automatic send_motion();
      int steps, peak_y, base_z, dip;
      steps = $urandom_range(3, 10);
      peak_y = $urandom_range(8000, 32000);
      base_z = $urandom_range(1000, 16000);
      dip = $urandom_range(0, 1) ? -$urandom_range(0, 12000) : 0;
      if ($urandom_range(2) == 0) begin
         send_sample($urandom_range(0, 400) - 200, dip, base_z);
         send_calibrate();
      end
      for (int s = 0; s <= steps; s++)
         send_sample($urandom_range(0, 600) - 300, peak_y * s / steps, base_z);
      for (int s = steps; s >= 0; s--)
         send_sample($urandom_range(0, 600) - 300, dip + (peak_y - dip) * s / steps,
                     base_z + $urandom_range(0, 200));
   endtask

   task automatic test_random_phase(int count);
      int stop_at;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         case ($urandom_range(9))
            0: send_calibrate();
            1: send_sample($urandom, $urandom, $urandom);
            2: send_sample(0, 0, 0);
            default: send_motion();
         endcase
      end
   endtask

   task automatic test_idling_phases();
      int pcts[4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{26, 26}};
      for (int p = 0; p < 4; p++) begin
         write_all($urandom_range(16000, 65535), $urandom_range(512, 6000),
                   $urandom_range(8000, 24000), $urandom_range(256, 4000));
         send_idle_pct = pcts[p][0];
         recv_stall_pct = pcts[p][1];
         test_random_phase(160);
         // Hold the sender until the block has caught up.
         wait_idle();
         test_random_phase(160);
      end
   endtask

   initial begin
      alpha_q16 = ALPHA_RESET;
      rise_level = RISE_RESET;
      peak_level = PEAK_RESET;
      fall_level = FALL_RESET;
      filt_q16 = 0;
      offset_q16 = 0;
      rel_q8 = '0;
      calibrated = 0;
      rising = 0;
      at_top = 0;
      rep_total = '0;
      send_idle_pct = 20;
      recv_stall_pct = 20;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_samples();
      test_register_extremes();
      test_idling_phases();
      wait_idle();
      $display("Sent %0d beats (%0d calibrations), checked %0d results,", beats_sent,
               cals_sent, beats_checked);
      $display("saw %0d completed repetitions and %0d skipped samples.", reps_seen,
               skips_seen);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #60000000;
      $display("Timeout with %0d results outstanding", pending_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
